@@ hw/rtl/bml_pkg.sv @@
// Shared types and constants for the byte-addressed load/store memory.
package bml_pkg;

    localparam int unsigned MEM_BYTES_DEF = 65536;
    localparam int unsigned CFG_W         = 17;
    localparam int unsigned CFG_RESET     = 65536;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned DATA_W        = 32;
    localparam int unsigned LANES         = 4;

    localparam logic [7:0]  RESET_BYTE    = 8'hA5;

    localparam logic        ACT_READ      = 1'b0;
    localparam logic        ACT_WRITE     = 1'b1;

    localparam logic [1:0]  SIZE_BYTE     = 2'd0;
    localparam logic [1:0]  SIZE_HALF     = 2'd1;
    localparam logic [1:0]  SIZE_WORD     = 2'd2;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_bank_ctl;

endpackage

@@ hw/rtl/bml_if.sv @@
// Request and response channel interfaces of the load/store memory.
interface bml_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [1:0]                    access_size;
    logic                          sign_extend;
    logic [bml_pkg::ADDR_W-1:0]    addr;
    logic [bml_pkg::DATA_W-1:0]    write_data;

    modport source (
        output valid, action, access_size, sign_extend, addr, write_data,
        input  ready
    );
    modport sink (
        input  valid, action, access_size, sign_extend, addr, write_data,
        output ready
    );
endinterface

interface bml_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bml_pkg::DATA_W-1:0]    read_data;
    logic                          out_of_range;

    modport source (
        output valid, read_data, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, read_data, out_of_range,
        output ready
    );
endinterface

@@ hw/rtl/byte_memory_load_store.sv @@
// Byte-addressed little-endian load/store memory built from four byte banks.
// Each request is registered in stage 1 (bank read registers), then its response in the output register.
// Throughput: one transaction per cycle, any alignment, limited by the single
// port of each bank, while the response side does not stall. After reset a
// clearing pass over all MEM_BYTES/4 rows fills every byte with 0xA5 while no
// request is accepted; size register resets to 65536 (saturated at MEM_BYTES).
module byte_memory_load_store #(
    parameter int unsigned MEM_BYTES = bml_pkg::MEM_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [bml_pkg::CFG_W-1:0]   i_cfg_wr_data,
    bml_req_if.sink                     i_req,
    bml_rsp_if.source                   o_rsp
);

    localparam int unsigned ROWS    = MEM_BYTES / bml_pkg::LANES;
    localparam int unsigned ROW_W   = $clog2(ROWS);
    localparam int unsigned LIM_W   = $clog2(MEM_BYTES + 1);
    localparam int unsigned LIM_RST = (bml_pkg::CFG_RESET < MEM_BYTES) ?
                                      bml_pkg::CFG_RESET : MEM_BYTES;

    bml_pkg::t_state r_state, n_state;
    logic [ROW_W-1:0] r_clr_row, n_clr_row;
    logic [LIM_W-1:0] r_limit;

    logic [bml_pkg::CFG_W:0] cfg_round;
    logic [31:0]             cfg_round32;

    logic                    accept;
    logic                    s1_advance;
    logic [2:0]              nbytes;

    logic [3:0][1:0]         lane_idx;
    logic [3:0][31:0]        lane_addr;
    logic [3:0]              lane_en;
    logic [3:0]              lane_ok;
    logic [3:0][ROW_W-1:0]   lane_row;
    logic [3:0][7:0]         lane_wdata;
    logic [3:0][7:0]         bank_rdata;
    logic [3:0][ROW_W-1:0]   bank_addr;
    logic [3:0][7:0]         bank_wdata;
    bml_pkg::t_bank_ctl [3:0] bank_ctl;

    logic                    r_s1_valid;
    logic                    r_s1_write;
    logic                    r_s1_sx;
    logic [1:0]              r_s1_size;
    logic [1:0]              r_s1_off;
    logic [3:0]              r_s1_mask;
    logic                    r_s1_oor;

    logic [31:0]             asm_data;

    logic                    r_out_valid;
    logic [31:0]             r_read_data;
    logic                    r_oor;

    // state machine: clearing pass, then normal operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bml_pkg::ST_CLEAR;
            r_clr_row <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr_row = r_clr_row;
        unique case (r_state)
            bml_pkg::ST_CLEAR: begin
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(ROWS - 1)) begin
                    n_state   = bml_pkg::ST_RUN;
                    n_clr_row = '0;
                end
            end
            bml_pkg::ST_RUN: begin
                n_state = bml_pkg::ST_RUN;
            end
            default: begin
                n_state = bml_pkg::ST_CLEAR;
            end
        endcase
    end

    // size in use: rounded up to 16, saturated at built depth
    always_comb begin
        cfg_round   = ({1'b0, i_cfg_wr_data} + (bml_pkg::CFG_W+1)'(15))
                      & ~(bml_pkg::CFG_W+1)'(15);
        cfg_round32 = 32'(cfg_round);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIM_W'(LIM_RST);
        end else if (i_cfg_wr_en) begin
            if (cfg_round32 > 32'(MEM_BYTES)) begin
                r_limit <= LIM_W'(MEM_BYTES);
            end else begin
                r_limit <= LIM_W'(cfg_round32);
            end
        end
    end

    // handshake
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == bml_pkg::ST_RUN) && (!r_s1_valid || s1_advance);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        case (i_req.access_size)
            bml_pkg::SIZE_BYTE: nbytes = 3'd1;
            bml_pkg::SIZE_HALF: nbytes = 3'd2;
            default:            nbytes = 3'd4;
        endcase
    end

    // per-bank lane: which byte of the transaction lands in bank b
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            lane_idx[b]   = 2'(b) - i_req.addr[1:0];
            lane_addr[b]  = i_req.addr + 32'(lane_idx[b]);
            lane_en[b]    = ({1'b0, lane_idx[b]} < nbytes);
            lane_ok[b]    = (lane_addr[b] < 32'(r_limit));
            lane_row[b]   = lane_addr[b][ROW_W+1:2];
            lane_wdata[b] = 8'(i_req.write_data >> {lane_idx[b], 3'b000});

            if (r_state == bml_pkg::ST_CLEAR) begin
                bank_ctl[b].we = 1'b1;
                bank_ctl[b].re = 1'b0;
                bank_addr[b]   = r_clr_row;
                bank_wdata[b]  = bml_pkg::RESET_BYTE;
            end else begin
                bank_ctl[b].we = accept && (i_req.action == bml_pkg::ACT_WRITE)
                                 && lane_en[b] && lane_ok[b];
                bank_ctl[b].re = accept && (i_req.action == bml_pkg::ACT_READ);
                bank_addr[b]   = lane_row[b];
                bank_wdata[b]  = lane_wdata[b];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        bml_bank #(
            .ROWS (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_ctl   (bank_ctl[g]),
            .i_addr  (bank_addr[g]),
            .i_wdata (bank_wdata[g]),
            .o_rdata (bank_rdata[g])
        );
    end

    // stage 1: memory access in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_write <= (i_req.action == bml_pkg::ACT_WRITE);
            r_s1_sx    <= i_req.sign_extend;
            r_s1_size  <= i_req.access_size;
            r_s1_off   <= i_req.addr[1:0];
            r_s1_mask  <= (i_req.action == bml_pkg::ACT_READ) ?
                          (lane_en & lane_ok) : 4'b0000;
            r_s1_oor   <= |(lane_en & ~lane_ok);
        end
    end

    // reassemble little-endian bytes from the banks
    always_comb begin
        logic [1:0] bsel;
        bsel = '0;
        for (int i = 0; i < 4; i++) begin
            bsel = r_s1_off + 2'(i);
            asm_data[8*i +: 8] = r_s1_mask[bsel] ? bank_rdata[bsel] : 8'h00;
        end
        if (!r_s1_write && r_s1_sx) begin
            if (r_s1_size == bml_pkg::SIZE_BYTE && asm_data[7]) begin
                asm_data[31:8] = '1;
            end else if (r_s1_size == bml_pkg::SIZE_HALF && asm_data[15]) begin
                asm_data[31:16] = '1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_read_data <= asm_data;
            r_oor       <= r_s1_oor;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.read_data    = r_read_data;
    assign o_rsp.out_of_range = r_oor;

endmodule

@@ hw/rtl/bml_bank.sv @@
// One byte-wide bank: synchronous memory with a registered read port.
module bml_bank #(
    parameter int unsigned ROWS = bml_pkg::MEM_BYTES_DEF / bml_pkg::LANES
) (
    input  logic                     i_clk,
    input  bml_pkg::t_bank_ctl       i_ctl,
    input  logic [$clog2(ROWS)-1:0]  i_addr,
    input  logic [7:0]               i_wdata,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [ROWS];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ bench/byte_memory_load_store_tb.sv @@
// Testbench for byte_memory_load_store: random and directed loads/stores vs a memory image.
module byte_memory_load_store_tb;

    localparam int unsigned MEM_BYTES  = bml_pkg::MEM_BYTES_DEF;
    localparam int unsigned CFG_W      = bml_pkg::CFG_W;
    localparam logic [1:0]  SIZE_RSVD  = 2'd3;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned PHASE_TXNS = 88;
    localparam int unsigned MAX_PRINTS = 100;

    typedef struct packed {
        logic                       action;
        logic [1:0]                 access_size;
        logic                       sign_extend;
        logic [bml_pkg::ADDR_W-1:0] addr;
        logic [bml_pkg::DATA_W-1:0] write_data;
    } t_mem_req;

    typedef struct packed {
        logic [bml_pkg::DATA_W-1:0] read_data;
        logic                       out_of_range;
    } t_mem_rsp;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    bml_req_if req_ch ();
    bml_rsp_if rsp_ch ();

    byte_memory_load_store #(
        .MEM_BYTES (MEM_BYTES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_req         (req_ch),
        .o_rsp         (rsp_ch)
    );

    // local copy of the memory and the size register
    logic [7:0]       memory_image [0:MEM_BYTES-1];
    logic [CFG_W-1:0] size_reg;

    t_mem_req    pending_req [$];
    t_mem_rsp    expected_rsp [$];
    int unsigned mismatch_cnt;
    int unsigned send_idle_pct;
    int unsigned rsp_stall_pct;
    logic        rsp_hold;
    event        hold_kick;

    always #1 clk = ~clk;

    initial begin
        #1000000;
        $display("byte_memory_load_store_tb: errors");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_cnt < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    function automatic logic [31:0] usable_bytes();
        logic [31:0] s;
        s = (32'(size_reg) + 32'd15) & 32'hFFFF_FFF0;
        if (s > MEM_BYTES)
            s = MEM_BYTES;
        return s;
    endfunction

    function automatic t_mem_rsp run_access(input t_mem_req r);
        t_mem_rsp    res;
        int unsigned nbytes;
        logic [31:0] lim;
        logic [31:0] a;
        lim = usable_bytes();
        res = '0;
        nbytes = (r.access_size == bml_pkg::SIZE_BYTE) ? 1 :
                 (r.access_size == bml_pkg::SIZE_HALF) ? 2 : 4;
        for (int i = 0; i < nbytes; i++) begin
            a = r.addr + 32'(i);
            if (a >= lim) begin
                res.out_of_range = 1'b1;
            end else if (r.action == bml_pkg::ACT_WRITE) begin
                memory_image[a] = r.write_data[8*i +: 8];
            end else begin
                res.read_data[8*i +: 8] = memory_image[a];
            end
        end
        if (r.action == bml_pkg::ACT_READ && r.sign_extend) begin
            if (nbytes == 1 && res.read_data[7])
                res.read_data[31:8] = '1;
            else if (nbytes == 2 && res.read_data[15])
                res.read_data[31:16] = '1;
        end
        return res;
    endfunction

    always @(posedge clk) begin : req_driver
        t_mem_req acc;
        t_mem_req nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                acc = '{req_ch.action, req_ch.access_size, req_ch.sign_extend,
                        req_ch.addr, req_ch.write_data};
                expected_rsp.push_back(run_access(acc));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_req.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= nxt.action;
                    req_ch.access_size <= nxt.access_size;
                    req_ch.sign_extend <= nxt.sign_extend;
                    req_ch.addr        <= nxt.addr;
                    req_ch.write_data  <= nxt.write_data;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : rsp_monitor
        t_mem_rsp want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsp.size() == 0) begin
                    flag_mismatch($sformatf("unexpected transaction, read_data %h",
                                            rsp_ch.read_data));
                end else begin
                    want = expected_rsp.pop_front();
                    if (rsp_ch.read_data !== want.read_data)
                        flag_mismatch($sformatf("read_data %h, expected %h",
                                                rsp_ch.read_data, want.read_data));
                    if (rsp_ch.out_of_range !== want.out_of_range)
                        flag_mismatch($sformatf("out_of_range %b, expected %b",
                                                rsp_ch.out_of_range, want.out_of_range));
                end
            end
            rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    // long receiver back-pressure
    always begin
        @(hold_kick);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    task automatic push_item(input logic act, input logic [1:0] sz, input logic sx,
                             input logic [31:0] addr, input logic [31:0] data);
        pending_req.push_back('{act, sz, sx, addr, data});
    endtask

    task automatic drain_all();
        @(negedge clk);
        while (pending_req.size() != 0 || req_ch.valid || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        size_reg = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] lim;
        int unsigned sel;
        lim = usable_bytes();
        sel = $urandom_range(99);
        if (sel < 35)
            return 32'($urandom_range(255));
        else if (sel < 55)
            return lim - 32'd4 + 32'($urandom_range(7));
        else if (sel < 65)
            return 32'hFFFF_FFFC + 32'($urandom_range(7));
        else if (sel < 85 && lim != 0)
            return 32'($urandom_range(lim - 1));
        return $urandom();
    endfunction

    function automatic t_mem_req random_req();
        t_mem_req r;
        r.action      = $urandom_range(1) ? bml_pkg::ACT_WRITE : bml_pkg::ACT_READ;
        r.access_size = 2'($urandom_range(3));
        r.sign_extend = 1'($urandom_range(1));
        r.addr        = pick_addr();
        r.write_data  = $urandom();
        return r;
    endfunction

    // mostly store/load pairs on the same address, the rest single accesses
    task automatic queue_random(input int unsigned n);
        int unsigned left;
        t_mem_req    w;
        t_mem_req    r;
        left = n;
        while (left != 0) begin
            w = random_req();
            if (left >= 2 && $urandom_range(99) < 60) begin
                w.action = bml_pkg::ACT_WRITE;
                r = random_req();
                r.action = bml_pkg::ACT_READ;
                r.addr = w.addr;
                pending_req.push_back(w);
                pending_req.push_back(r);
                left -= 2;
            end else begin
                pending_req.push_back(w);
                left--;
            end
        end
    endtask

    initial begin : main_seq
        logic [CFG_W-1:0] sizes [8];
        int unsigned      idle_send [4];
        int unsigned      idle_rsp  [4];
        sizes = '{17'd65536, 17'd16, 17'd17, 17'd0, 17'd100, 17'd131071, 17'd65535, 17'd1};
        idle_send = '{0, 56, 0, 24};
        idle_rsp  = '{0, 0, 56, 24};
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = bml_pkg::ACT_READ;
        req_ch.access_size = bml_pkg::SIZE_BYTE;
        req_ch.sign_extend = 1'b0;
        req_ch.addr        = '0;
        req_ch.write_data  = '0;
        rsp_ch.ready       = 1'b0;
        rsp_hold           = 1'b0;
        mismatch_cnt       = 0;
        send_idle_pct      = 0;
        rsp_stall_pct      = 0;
        size_reg           = CFG_W'(bml_pkg::CFG_RESET);
        for (int i = 0; i < MEM_BYTES; i++)
            memory_image[i] = bml_pkg::RESET_BYTE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b0, 32'h0000_0000, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_BYTE, 1'b1, 32'h0000_0001, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_HALF, 1'b1, 32'h0000_0002, 32'h0);
        push_item(bml_pkg::ACT_WRITE, bml_pkg::SIZE_WORD, 1'b1, 32'h0000_0000, 32'h80FF_7F01);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_BYTE, 1'b1, 32'h0000_0000, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_BYTE, 1'b1, 32'h0000_0003, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_BYTE, 1'b0, 32'h0000_0003, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_HALF, 1'b1, 32'h0000_0002, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_HALF, 1'b0, 32'h0000_0001, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b1, 32'h0000_0000, 32'h0);
        push_item(bml_pkg::ACT_WRITE, SIZE_RSVD,          1'b0, 32'h0000_0005, 32'hFFFF_FFFF);
        push_item(bml_pkg::ACT_READ,  SIZE_RSVD,          1'b1, 32'h0000_0004, 32'h0);
        push_item(bml_pkg::ACT_WRITE, bml_pkg::SIZE_HALF, 1'b0, 32'h0000_FFFF, 32'h0000_1234);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b0, 32'h0000_FFFE, 32'h0);
        push_item(bml_pkg::ACT_WRITE, bml_pkg::SIZE_WORD, 1'b0, 32'hFFFF_FFFE, 32'hDEAD_BEEF);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b0, 32'hFFFF_FFFF, 32'h0);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_BYTE, 1'b1, 32'h0001_0000, 32'h0);
        push_item(bml_pkg::ACT_WRITE, bml_pkg::SIZE_BYTE, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b1, 32'hFFFF_FFFC, 32'h0);
        drain_all();
        write_size(17'd0);
        push_item(bml_pkg::ACT_WRITE, bml_pkg::SIZE_BYTE, 1'b0, 32'h0000_0000, 32'h0000_0055);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b0, 32'h0000_0000, 32'h0);
        drain_all();
        write_size(17'd131071);
        push_item(bml_pkg::ACT_READ,  bml_pkg::SIZE_WORD, 1'b0, 32'h0000_FFFC, 32'h0);
        drain_all();

        // random phases
        for (int p = 0; p < 8; p++) begin
            write_size(sizes[p]);
            send_idle_pct = idle_send[p % 4];
            rsp_stall_pct = idle_rsp[p % 4];
            if (p == 4)
                -> hold_kick;
            queue_random(PHASE_TXNS / 2);
            drain_all();
            queue_random(PHASE_TXNS - PHASE_TXNS / 2);
            drain_all();
        end

        repeat (8) @(negedge clk);
        if (mismatch_cnt == 0)
            $display("byte_memory_load_store_tb: clean");
        else
            $display("byte_memory_load_store_tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bml_pkg.sv
hw/rtl/bml_if.sv
hw/rtl/bml_bank.sv
hw/rtl/byte_memory_load_store.sv
bench/byte_memory_load_store_tb.sv
